// File: rtl/sma_pkg.sv
// Shared types and constants for the sign-magnitude ALU.
package sma_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned MagW  = WordW - 1;
  localparam int unsigned KindW = 3;
  // Magnitude split for the multiplier partial products.
  localparam int unsigned MulLoW = 16;
  localparam int unsigned MulHiW = MagW - MulLoW;

  typedef enum logic [KindW-1:0] {
    KindAdd = 3'd0,
    KindSub = 3'd1,
    KindMul = 3'd2,
    KindGt  = 3'd3,
    KindEq  = 3'd4
  } kind_e;

  // First stage: unpacked operands, magnitude compare, partial products.
  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic                sign_a;
    logic                sign_b;   // already flipped for subtract
    logic                sign_b_raw;
    logic [MagW-1:0]     mag_a;
    logic [MagW-1:0]     mag_b;
    logic                a_ge_b;
    logic                mag_eq;
    logic                zero_a;
    logic                zero_b;
    logic [2*MulLoW-1:0] mul_lo;     // low half times low half
    logic [MulHiW-1:0]   mul_cross;  // cross terms, only the bits below 2^31 matter
  } s1_t;

  // Second stage: candidate results waiting for the final select.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [MagW-1:0]  mul_mag;
    logic             mul_neg;
    logic [MagW-1:0]  as_mag;
    logic             as_neg;
    logic             gt;
    logic             eq;
  } s2_t;

  // Pack sign and magnitude; a zero magnitude is always +0.
  function automatic logic [WordW-1:0] pack_sm(input logic neg, input logic [MagW-1:0] mag);
    pack_sm = {neg && (mag != '0), mag};
  endfunction

endpackage

// File: rtl/sign_magnitude_alu.sv
// Three-stage pipelined sign-magnitude ALU (add, subtract, multiply, compare).
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, kind_i, operand_a/b_i | in
//  output  | out_valid_o, out_stall_i, result_value_o,     | out
//          | compare_true_o                               |
//
// One transaction per cycle while the output does not stall; the stages are
// operand compare and 16-bit partial products, product sum / add-subtract, result select and pack.
// Reset clears the stage valid bits only; the data registers are not reset.
// A stall on the output freezes the whole pipe; in_stall_o follows it
// combinationally, so nothing is dropped or repeated.
module sign_magnitude_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sma_pkg::KindW-1:0]   kind_i,
  input  logic [sma_pkg::WordW-1:0]   operand_a_i,
  input  logic [sma_pkg::WordW-1:0]   operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sma_pkg::WordW-1:0]   result_value_o,
  output logic                        compare_true_o
);

  localparam int unsigned MagW = sma_pkg::MagW;
  localparam int unsigned LoW  = sma_pkg::MulLoW;
  localparam int unsigned HiW  = sma_pkg::MulHiW;

  logic advance;

  logic          s1_valid_q;
  sma_pkg::s1_t  s1_d, s1_q;
  logic          s2_valid_q;
  sma_pkg::s2_t  s2_d, s2_q;
  logic          out_valid_q;
  logic [sma_pkg::WordW-1:0] result_d, result_q;
  logic          flag_d, flag_q;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  // Stage 1: split operands, compare magnitudes, partial products.
  always_comb begin
    s1_d.kind       = kind_i;
    s1_d.sign_a     = operand_a_i[MagW];
    s1_d.sign_b_raw = operand_b_i[MagW];
    s1_d.sign_b     = operand_b_i[MagW] ^ (kind_i == sma_pkg::KindSub);
    s1_d.mag_a      = operand_a_i[MagW-1:0];
    s1_d.mag_b      = operand_b_i[MagW-1:0];
    s1_d.a_ge_b     = operand_a_i[MagW-1:0] >= operand_b_i[MagW-1:0];
    s1_d.mag_eq     = operand_a_i[MagW-1:0] == operand_b_i[MagW-1:0];
    s1_d.zero_a     = operand_a_i[MagW-1:0] == '0;
    s1_d.zero_b     = operand_b_i[MagW-1:0] == '0;
    s1_d.mul_lo     = operand_a_i[LoW-1:0] * operand_b_i[LoW-1:0];
    // high times high lands at 2^32 and drops out of the 31-bit magnitude
    s1_d.mul_cross  = HiW'(operand_a_i[MagW-1:LoW] * operand_b_i[LoW-1:0]
                           + operand_a_i[LoW-1:0] * operand_b_i[MagW-1:LoW]);
  end

  // Stage 2: product sum, add/subtract magnitudes, signed compares.
  logic neg_a, neg_b;
  always_comb begin
    neg_a = s1_q.sign_a && !s1_q.zero_a;
    neg_b = s1_q.sign_b_raw && !s1_q.zero_b;
    s2_d.kind    = s1_q.kind;
    s2_d.mul_mag = MagW'(s1_q.mul_lo) + {s1_q.mul_cross, {LoW{1'b0}}};
    s2_d.mul_neg = s1_q.sign_a ^ s1_q.sign_b_raw;
    if (s1_q.sign_a == s1_q.sign_b) begin
      s2_d.as_mag = MagW'(s1_q.mag_a + s1_q.mag_b);
      s2_d.as_neg = s1_q.sign_a;
    end else if (s1_q.a_ge_b) begin
      s2_d.as_mag = MagW'(s1_q.mag_a - s1_q.mag_b);
      s2_d.as_neg = s1_q.sign_a;
    end else begin
      s2_d.as_mag = MagW'(s1_q.mag_b - s1_q.mag_a);
      s2_d.as_neg = s1_q.sign_b;
    end
    s2_d.eq = s1_q.mag_eq && (s1_q.zero_a || (s1_q.sign_a == s1_q.sign_b_raw));
    if (neg_a != neg_b) begin
      s2_d.gt = neg_b;
    end else if (neg_a) begin
      s2_d.gt = !s1_q.a_ge_b;
    end else begin
      s2_d.gt = s1_q.a_ge_b && !s1_q.mag_eq;
    end
  end

  // Stage 3: pick the result for the operation.
  always_comb begin
    result_d = '0;
    flag_d   = 1'b0;
    unique case (sma_pkg::kind_e'(s2_q.kind))
      sma_pkg::KindAdd, sma_pkg::KindSub: begin
        result_d = sma_pkg::pack_sm(s2_q.as_neg, s2_q.as_mag);
      end
      sma_pkg::KindMul: begin
        result_d = sma_pkg::pack_sm(s2_q.mul_neg, s2_q.mul_mag);
      end
      sma_pkg::KindGt: flag_d = s2_q.gt;
      sma_pkg::KindEq: flag_d = s2_q.eq;
      default: begin
        result_d = '0;
        flag_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      result_q <= result_d;
      flag_q   <= flag_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign compare_true_o = flag_q;

endmodule

// File: rtl/sma_checker.sv
// Port-level checks for the sign-magnitude ALU, bound to the top level.
module sma_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [sma_pkg::WordW-1:0] result_value_o,
  input logic                      compare_true_o
);

  localparam logic [sma_pkg::WordW-1:0] NegZero = {1'b1, {sma_pkg::MagW{1'b0}}};

  // A held transaction stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(compare_true_o))
    else $error("output transaction changed while stalled");

  // The input side only backs up when the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Zero results are always +0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_value_o != NegZero)
    else $error("negative zero on result");

  // A set compare flag comes with a value of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == '0)
    else $error("flag set together with nonzero value");

endmodule

bind sign_magnitude_alu sma_checker u_sma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .compare_true_o (compare_true_o)
);
